>>> rtl/tpi_pkg.sv
// Shared widths, types and constants for the three-plane intersection pipeline.
package tpi_pkg;

  localparam int NRM_W       = 16;  // normal component, Q2.14
  localparam int OFS_W       = 24;  // plane offset, Q16.8
  localparam int PROD_W      = 32;  // normal by normal product
  localparam int CRS_W       = 33;  // cross product component
  localparam int TRI_W       = 50;  // triple product, Q.42
  localparam int NUM_W       = 58;  // numerator, Q.36
  localparam int MAG_W       = 48;  // magnitude of the triple product
  localparam int AN_W        = 56;  // magnitude of the numerator
  localparam int THR_W       = 28;  // threshold register, Q.28
  localparam int PNT_W       = 32;  // output coordinate, Q24.8
  localparam int FRAC_SHIFT  = 14;  // quotient scaling and Q.28 to Q.42
  localparam int DIV_STEPS   = 32;  // quotient bits, one per stage
  localparam int LOW_W       = DIV_STEPS - FRAC_SHIFT;
  localparam int CMP_W       = MAG_W + LOW_W;
  localparam int PRE_STAGES  = 6;
  localparam int STAGES      = PRE_STAGES + DIV_STEPS + 1;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(256);

  // Rotation of axis and plane indexes for cross products
  localparam int NXT1 [3] = '{1, 2, 0};
  localparam int NXT2 [3] = '{2, 0, 1};

  typedef logic signed [NRM_W-1:0] nrm_t;
  typedef logic signed [OFS_W-1:0] ofs_t;

  // Operands of one divider lane
  typedef struct packed {
    logic [AN_W-1:0]  an;
    logic [MAG_W-1:0] ad;
    logic             neg;
    logic             ov;
  } div_in_t;

  // Result of one divider lane
  typedef struct packed {
    logic [PNT_W-1:0] value;
    logic             sat;
  } div_out_t;

endpackage

>>> rtl/three_plane_intersection.sv
// Top level: common point of three planes, fully pipelined.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    three normals and offsets
//   out      output     out_valid / out_ready  point_x/y/z, found, saturated
//   cfg      input      cfg_valid / cfg_ready  cfg_data: parallel threshold
//
// One item per cycle unless the output stalls: six stages of products,
// sums and compares, then a 32-stage divider (one quotient bit per stage) per
// coordinate and a rounding stage whose register drives the outputs.
// Reset clears the stage valid bits and loads the threshold with 256.
// A stall at the output fills empty stages first; ready never drops while
// any stage holds a bubble.
module three_plane_intersection (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [15:0]         first_normal_x,
  input  logic signed [15:0]         first_normal_y,
  input  logic signed [15:0]         first_normal_z,
  input  logic signed [23:0]         first_offset,
  input  logic signed [15:0]         second_normal_x,
  input  logic signed [15:0]         second_normal_y,
  input  logic signed [15:0]         second_normal_z,
  input  logic signed [23:0]         second_offset,
  input  logic signed [15:0]         third_normal_x,
  input  logic signed [15:0]         third_normal_y,
  input  logic signed [15:0]         third_normal_z,
  input  logic signed [23:0]         third_offset,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [31:0]         point_x,
  output logic signed [31:0]         point_y,
  output logic signed [31:0]         point_z,
  output logic                       found,
  output logic                       saturated,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tpi_pkg::THR_W-1:0]  cfg_data
);
  import tpi_pkg::*;

  // Threshold register
  logic [THR_W-1:0] thr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr <= cfg_data;
    end
  end

  // Stage valids and enables: a stage advances when any later stage is empty
  logic [STAGES-1:0] stage_valid;
  logic [STAGES-1:0] en;

  always_comb begin
    for (int i = 0; i < STAGES; i++) begin
      en[i] = out_ready | ~&(stage_valid | ({STAGES{1'b1}} >> (STAGES - i)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (en[0]) begin
        stage_valid[0] <= in_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) begin
          stage_valid[i] <= stage_valid[i-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = stage_valid[STAGES-1];

  // Gather the input fields
  nrm_t nv [3][3];
  ofs_t dv [3];

  assign nv[0][0] = first_normal_x;
  assign nv[0][1] = first_normal_y;
  assign nv[0][2] = first_normal_z;
  assign nv[1][0] = second_normal_x;
  assign nv[1][1] = second_normal_y;
  assign nv[1][2] = second_normal_z;
  assign nv[2][0] = third_normal_x;
  assign nv[2][1] = third_normal_y;
  assign nv[2][2] = third_normal_z;
  assign dv[0]    = first_offset;
  assign dv[1]    = second_offset;
  assign dv[2]    = third_offset;

  // Stage 1: cross product partial products
  logic signed [PROD_W-1:0] s1_pp [3][3];
  logic signed [PROD_W-1:0] s1_pm [3][3];
  nrm_t                     s1_a  [3];
  ofs_t                     s1_d  [3];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          s1_pp[j][k] <= nv[NXT1[j]][NXT1[k]] * nv[NXT2[j]][NXT2[k]];
          s1_pm[j][k] <= nv[NXT1[j]][NXT2[k]] * nv[NXT2[j]][NXT1[k]];
        end
        s1_a[j] <= nv[0][j];
        s1_d[j] <= dv[j];
      end
    end
  end

  // Stage 2: cross products
  logic signed [CRS_W-1:0] s2_c [3][3];
  nrm_t                    s2_a [3];
  ofs_t                    s2_d [3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          s2_c[j][k] <= CRS_W'(s1_pp[j][k]) - CRS_W'(s1_pm[j][k]);
        end
        s2_a[j] <= s1_a[j];
        s2_d[j] <= s1_d[j];
      end
    end
  end

  // Stage 3: triple product and numerator terms
  logic signed [TRI_W-1:0] s3_t [3];
  logic signed [NUM_W-1:0] s3_n [3][3];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < 3; k++) begin
        s3_t[k] <= s2_a[k] * s2_c[0][k];
        for (int j = 0; j < 3; j++) begin
          s3_n[j][k] <= s2_d[j] * s2_c[j][k];
        end
      end
    end
  end

  // Stage 4: sums, numerator negated
  logic signed [TRI_W-1:0] s4_t;
  logic signed [NUM_W-1:0] s4_n [3];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_t <= s3_t[0] + s3_t[1] + s3_t[2];
      for (int k = 0; k < 3; k++) begin
        s4_n[k] <= -(s3_n[0][k] + s3_n[1][k] + s3_n[2][k]);
      end
    end
  end

  // Stage 5: magnitudes and quotient signs
  logic [MAG_W-1:0] s5_ad;
  logic [AN_W-1:0]  s5_an  [3];
  logic             s5_neg [3];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_ad <= (s4_t < 0) ? MAG_W'(-s4_t) : MAG_W'(s4_t);
      for (int k = 0; k < 3; k++) begin
        s5_an[k]  <= (s4_n[k] < 0) ? AN_W'(-s4_n[k]) : AN_W'(s4_n[k]);
        s5_neg[k] <= (s4_n[k] < 0) != (s4_t < 0);
      end
    end
  end

  // Stage 6: degenerate test and early overflow test
  div_in_t s6_lane [3];
  logic    s6_found;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_found <= s5_ad > MAG_W'({thr, {FRAC_SHIFT{1'b0}}});
      for (int k = 0; k < 3; k++) begin
        s6_lane[k].an  <= s5_an[k];
        s6_lane[k].ad  <= s5_ad;
        s6_lane[k].neg <= s5_neg[k];
        s6_lane[k].ov  <= {{(CMP_W-AN_W){1'b0}}, s5_an[k]} >=
                          {s5_ad, {LOW_W{1'b0}}};
      end
    end
  end

  // Carry the found flag alongside the divider stages
  logic found_q [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (en[PRE_STAGES]) begin
      found_q[0] <= s6_found;
    end
    for (int i = 1; i <= DIV_STEPS; i++) begin
      if (en[PRE_STAGES+i]) begin
        found_q[i] <= found_q[i-1];
      end
    end
  end

  // Divider lanes
  div_out_t lane_out [3];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    tpi_div_lane u_lane (
      .clk  (clk),
      .en   (en[PRE_STAGES +: DIV_STEPS+1]),
      .din  (s6_lane[k]),
      .dout (lane_out[k])
    );
  end

  // Zero the point for degenerate planes
  assign found     = found_q[DIV_STEPS];
  assign point_x   = found ? lane_out[0].value : '0;
  assign point_y   = found ? lane_out[1].value : '0;
  assign point_z   = found ? lane_out[2].value : '0;
  assign saturated = found & (lane_out[0].sat | lane_out[1].sat | lane_out[2].sat);

`ifndef ASSERT_OFF
  // Input stalls only behind a full pipeline with a stalled output
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready && (&stage_valid)))
    else $error("input stalled with room in the pipeline");

  // An input transfer occupies the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> stage_valid[0])
    else $error("accepted item did not enter the pipeline");

  // Saturation is only reported for a found point
  a_sat_found: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!saturated || found))
    else $error("saturation flagged for degenerate planes");
`endif

endmodule

>>> rtl/tpi_div_lane.sv
// One coordinate lane: pipelined restoring divider with rounding and saturation.
module tpi_div_lane (
  input  logic                       clk,
  input  logic [tpi_pkg::DIV_STEPS:0] en,
  input  tpi_pkg::div_in_t           din,
  output tpi_pkg::div_out_t          dout
);
  import tpi_pkg::*;

  logic [MAG_W-1:0] r   [DIV_STEPS];
  logic [PNT_W-1:0] q   [DIV_STEPS];
  logic [LOW_W-1:0] lo  [DIV_STEPS];
  logic [MAG_W-1:0] ad  [DIV_STEPS];
  logic             neg [DIV_STEPS];
  logic             ov  [DIV_STEPS];

  // One quotient bit per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [MAG_W-1:0] r_in;
    logic [MAG_W-1:0] ad_in;
    logic [PNT_W-1:0] q_in;
    logic [LOW_W-1:0] lo_in;
    logic             neg_in;
    logic             ov_in;
    logic [MAG_W:0]   rs;
    logic             take;

    if (k == 0) begin : g_first
      assign r_in   = MAG_W'(din.an[AN_W-1:LOW_W]);
      assign ad_in  = din.ad;
      assign q_in   = '0;
      assign lo_in  = din.an[LOW_W-1:0];
      assign neg_in = din.neg;
      assign ov_in  = din.ov;
    end else begin : g_next
      assign r_in   = r[k-1];
      assign ad_in  = ad[k-1];
      assign q_in   = q[k-1];
      assign lo_in  = lo[k-1];
      assign neg_in = neg[k-1];
      assign ov_in  = ov[k-1];
    end

    // Bring down the next dividend bit; the low bits below the scaling are zero
    if (DIV_STEPS - 1 - k >= FRAC_SHIFT) begin : g_bit
      assign rs = {r_in, lo_in[DIV_STEPS-1-k-FRAC_SHIFT]};
    end else begin : g_zero
      assign rs = {r_in, 1'b0};
    end

    assign take = rs >= {1'b0, ad_in};

    always_ff @(posedge clk) begin
      if (en[k]) begin
        r[k]   <= take ? MAG_W'(rs - {1'b0, ad_in}) : MAG_W'(rs);
        q[k]   <= {q_in[PNT_W-2:0], take};
        lo[k]  <= lo_in;
        ad[k]  <= ad_in;
        neg[k] <= neg_in;
        ov[k]  <= ov_in;
      end
    end
  end

  // Round half away from zero, then clamp to the signed output range
  logic             rnd;
  logic [PNT_W:0]   q_rnd;
  logic             sat;
  logic [PNT_W-1:0] value;

  always_comb begin
    rnd   = {r[DIV_STEPS-1], 1'b0} >= {1'b0, ad[DIV_STEPS-1]};
    q_rnd = {1'b0, q[DIV_STEPS-1]} + (PNT_W+1)'(rnd);
    if (neg[DIV_STEPS-1]) begin
      sat   = ov[DIV_STEPS-1] || (q_rnd > ((PNT_W+1)'(1) << (PNT_W-1)));
      value = sat ? {1'b1, {(PNT_W-1){1'b0}}} : PNT_W'(-q_rnd);
    end else begin
      sat   = ov[DIV_STEPS-1] || (q_rnd > {2'b00, {(PNT_W-1){1'b1}}});
      value = sat ? {1'b0, {(PNT_W-1){1'b1}}} : q_rnd[PNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[DIV_STEPS]) begin
      dout.value <= value;
      dout.sat   <= sat;
    end
  end

endmodule

>>> verif/three_plane_intersection_test.sv
// Testbench for the three-plane intersection block: random and directed plane triples.
module three_plane_intersection_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tpi_pkg::*;

  typedef struct {
    logic signed [15:0] n [3][3];
    logic signed [23:0] d [3];
  } planes_t;

  typedef struct {
    logic signed [31:0] p [3];
    logic               found;
    logic               sat;
  } point_t;

  // Scoreboard: predicts the point of each accepted triple and checks results.
  class point_board;
    logic [THR_W-1:0] thr;
    point_t           pending [$];
    int               errors;

    function new();
      thr = THR_RESET;
      errors = 0;
    endfunction

    // Round num*2^14/den to nearest, ties away, then clamp to 32 bits.
    function automatic logic signed [31:0] quotient(longint num, longint den,
                                                    ref logic sat);
      logic          neg;
      logic [127:0]  an, ad, q, r;
      neg = (num < 0) != (den < 0);
      an = 128'((num < 0) ? -num : num);
      ad = 128'((den < 0) ? -den : den);
      an = an << 14;
      q = an / ad;
      r = an % ad;
      if (r >= ad - r) q = q + 128'd1;
      if (neg) begin
        if (q > 128'h8000_0000) begin
          sat = 1'b1;
          q = 128'h8000_0000;
        end
        return -q[31:0];
      end
      if (q > 128'h7FFF_FFFF) begin
        sat = 1'b1;
        q = 128'h7FFF_FFFF;
      end
      return q[31:0];
    endfunction

    function void note_planes(planes_t pl);
      longint a [3], b [3], c [3], c1 [3], c2 [3], c3 [3];
      longint t, at, lim, d1, d2, d3, num;
      point_t e;
      for (int k = 0; k < 3; k++) begin
        a[k] = pl.n[0][k];
        b[k] = pl.n[1][k];
        c[k] = pl.n[2][k];
      end
      d1 = pl.d[0];
      d2 = pl.d[1];
      d3 = pl.d[2];
      for (int k = 0; k < 3; k++) begin
        c1[k] = b[(k+1)%3] * c[(k+2)%3] - b[(k+2)%3] * c[(k+1)%3];
        c2[k] = c[(k+1)%3] * a[(k+2)%3] - c[(k+2)%3] * a[(k+1)%3];
        c3[k] = a[(k+1)%3] * b[(k+2)%3] - a[(k+2)%3] * b[(k+1)%3];
      end
      t = a[0] * c1[0] + a[1] * c1[1] + a[2] * c1[2];
      at = (t < 0) ? -t : t;
      lim = longint'(thr) << 14;
      e.sat = 1'b0;
      e.found = 1'b0;
      for (int k = 0; k < 3; k++) e.p[k] = '0;
      if (at > lim) begin
        e.found = 1'b1;
        for (int k = 0; k < 3; k++) begin
          num = -(d1 * c1[k] + d2 * c2[k] + d3 * c3[k]);
          e.p[k] = quotient(num, t, e.sat);
        end
      end
      pending.push_back(e);
    endfunction

    function void check_point(point_t got);
      point_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer");
        return;
      end
      e = pending.pop_front();
      if (got.p[0] !== e.p[0] || got.p[1] !== e.p[1] || got.p[2] !== e.p[2] ||
          got.found !== e.found || got.sat !== e.sat) begin
        errors++;
        if (errors <= 10)
          $display("point mismatch: exp %0d %0d %0d f%0b s%0b got %0d %0d %0d f%0b s%0b",
                   e.p[0], e.p[1], e.p[2], e.found, e.sat,
                   got.p[0], got.p[1], got.p[2], got.found, got.sat);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, out_ready = 1'b0, cfg_valid = 1'b0;
  logic in_ready, out_valid, cfg_ready, found, saturated;
  logic [THR_W-1:0] cfg_data = '0;
  logic signed [31:0] point_x, point_y, point_z;
  planes_t cur;
  int send_idle, recv_idle;
  longint cycles = 0;
  point_board board = new();

  wire signed [15:0] nx0 = cur.n[0][0], ny0 = cur.n[0][1], nz0 = cur.n[0][2];
  wire signed [15:0] nx1 = cur.n[1][0], ny1 = cur.n[1][1], nz1 = cur.n[1][2];
  wire signed [15:0] nx2 = cur.n[2][0], ny2 = cur.n[2][1], nz2 = cur.n[2][2];
  wire signed [23:0] d0 = cur.d[0], d1 = cur.d[1], d2 = cur.d[2];

  three_plane_intersection u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .first_normal_x(nx0), .first_normal_y(ny0), .first_normal_z(nz0), .first_offset(d0),
    .second_normal_x(nx1), .second_normal_y(ny1), .second_normal_z(nz1),
    .second_offset(d1),
    .third_normal_x(nx2), .third_normal_y(ny2), .third_normal_z(nz2), .third_offset(d2),
    .out_valid(out_valid), .out_ready(out_ready),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .found(found), .saturated(saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample result transfers and advance the watchdog.
  always @(posedge clk) begin
    point_t got;
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("Mismatches found");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      got.p[0] = point_x;
      got.p[1] = point_y;
      got.p[2] = point_z;
      got.found = found;
      got.sat = saturated;
      board.check_point(got);
    end
  end

  // Randomly stall the receiver.
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  task automatic send_planes(planes_t pl);
    while ($urandom_range(99) < send_idle) @(negedge clk);
    cur = pl;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    board.note_planes(pl);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (45) @(negedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    drain();
    cfg_data = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    board.thr = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic signed [15:0] rand_norm(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      default: return $signed(16'($urandom_range(32767))) - 16'sd16384;
    endcase
  endfunction

  function automatic planes_t rand_planes();
    planes_t pl;
    int mode, sz;
    mode = $urandom_range(9);
    sz = $urandom_range(3);
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) pl.n[i][k] = rand_norm(mode == 0 ? 1 : mode % 3);
      case (sz)
        0: pl.d[i] = $signed(24'($urandom_range(511))) - 24'sd256;
        1: pl.d[i] = $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
        default: pl.d[i] = 24'($urandom);
      endcase
    end
    // Degenerate shapes: repeated normal or a scaled normal
    if (mode == 9) pl.n[2] = pl.n[$urandom_range(1)];
    if (mode == 8) for (int k = 0; k < 3; k++) pl.n[1][k] = pl.n[0][k] >>> 1;
    return pl;
  endfunction

  function automatic planes_t axis_planes(logic signed [15:0] s,
                                          logic signed [23:0] o0, o1, o2);
    planes_t pl;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) pl.n[i][k] = (i == k) ? s : 16'sd0;
    pl.d[0] = o0;
    pl.d[1] = o1;
    pl.d[2] = o2;
    return pl;
  endfunction

  // Send a run of random triples with fixed sender and receiver idling.
  task automatic random_phase(int count, int s_idle, int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int i = 0; i < count; i++) begin
      send_planes(rand_planes());
    end
  endtask

  initial begin
    planes_t pl;
    send_idle = 0;
    recv_idle = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: unit axes, extreme offsets, zero numerator, degenerate, saturation
    send_planes(axis_planes(16'sd16384, 24'sd256, -24'sd512, 24'sd0));
    send_planes(axis_planes(16'sd16384, 24'sh7FFFFF, 24'sh800000, 24'sd1));
    send_planes(axis_planes(-16'sd16384, 24'sd0, 24'sd0, 24'sd0));
    send_planes(axis_planes(16'sh8000, 24'sh7FFFFF, 24'sh800000, -24'sd1));
    send_planes(axis_planes(16'sh7FFF, 24'sd3, -24'sd3, 24'sd5));
    send_planes(axis_planes(16'sd1, 24'sd1, -24'sd1, 24'sd0));
    send_planes(axis_planes(16'sd8, 24'sh7FFFFF, 24'sh800000, 24'sd100));
    send_planes(axis_planes(16'sd2, 24'sd1, 24'sd3, -24'sd5));
    send_planes(axis_planes(16'sd0, 24'sd9, 24'sd9, 24'sd9));
    pl = axis_planes(16'sh7FFF, 24'sh7FFFFF, 24'sh800000, 24'sd7);
    pl.n[2] = pl.n[0];
    send_planes(pl);
    pl = axis_planes(16'sh8000, 24'sh800000, 24'sh800000, 24'sh800000);
    pl.n[0][1] = 16'sh7FFF;
    pl.n[1][2] = 16'sh7FFF;
    pl.n[2][0] = 16'sh7FFF;
    send_planes(pl);
    // Pause until the pipeline is empty
    drain();
    write_threshold('0);
    send_planes(axis_planes(16'sd1, 24'sd1, -24'sd1, 24'sd2));
    send_planes(axis_planes(16'sd0, 24'sd1, -24'sd1, 24'sd2));
    write_threshold({THR_W{1'b1}});
    send_planes(axis_planes(16'sh8000, 24'sd1, -24'sd1, 24'sd2));
    send_planes(axis_planes(16'sd16384, 24'sd1, -24'sd1, 24'sd2));

    write_threshold(THR_RESET);
    random_phase(500, 10, 45);
    write_threshold('0);
    random_phase(450, 45, 10);
    write_threshold(28'd1 << $urandom_range(27));
    random_phase(480, 0, 0);
    drain();

    if (board.pending.size() == 0 && board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
